### src/vbh_pkg.sv
package vbh_pkg;

  localparam int MAX_BINS   = 64;
  localparam int EDGE_DEPTH = MAX_BINS + 1;
  localparam int EC_W       = $clog2(MAX_BINS + 2);
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int BIN_AW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  localparam int MODE_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 32;
  localparam int IDXC_W     = (EC_W > INDEX_W) ? EC_W : INDEX_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 3'd0,
    MODE_SET    = 3'd1,
    MODE_APPEND = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_BAD     = 2'd2
  } status_e;

endpackage

### src/vbh_in_if.sv
interface vbh_in_if import vbh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, output mode, output value, output index, input ready);
  modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

### src/vbh_out_if.sv
interface vbh_out_if import vbh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  bin_num;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  sample_total;

  modport source (output valid, output status, output bin_num, output count,
                  output sample_total, input ready);
  modport sink   (input valid, input status, input bin_num, input count,
                  input sample_total, output ready);
endinterface

### src/vbh_ram.sv
module vbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/variable_bin_histogram.sv
// variable_bin_histogram: one beat in, one beat out, in_i ready only while the sequencer idles
// sample: binary search over the edge table, ceil(log2(bins)) search steps, then the count update
// the search reuses one edge compare, one edge memory read per step
// read bin and append: one count memory read; set, clear, outside and refused beats go straight to emit
// while the previous result waits on out_o.ready the sequencer holds in emit and takes no new beat
// rst_ni clears edge count, sample total, count valid bits and output valid at once; no clearing pass
module variable_bin_histogram import vbh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  vbh_in_if.sink    in_i,
  vbh_out_if.source out_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_SRCH = 7'b0000100,
    ST_CMP  = 7'b0001000,
    ST_CRD  = 7'b0010000,
    ST_CWR  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [MODE_W-1:0]         mode_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [INDEX_W-1:0]        idx_q;

  logic [EC_W-1:0]    ec_q, ec_d;
  logic [COUNT_W-1:0] samples_q, samples_d;
  logic [MAX_BINS-1:0] vld_q, vld_d;
  logic signed [VALUE_W-1:0] first_q, first_d, last_q, last_d;
  logic [EC_W-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [INDEX_W-1:0]  res_bin_q, res_bin_d;
  logic [COUNT_W-1:0]  res_count_q, res_count_d;

  logic                out_vld_q, out_vld_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [INDEX_W-1:0]  out_bin_q;
  logic [COUNT_W-1:0]  out_count_q, out_total_q;
  logic                out_load;

  logic               edge_we, edge_re;
  logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
  logic [VALUE_W-1:0] edge_wdata, edge_rdata;
  logic               cnt_we, cnt_re;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata, cnt_cur;

  logic               in_fire;
  logic [EC_W:0]      mid_sum;
  logic [VALUE_W:0]   next_edge;
  logic               read_ok;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign next_edge = {last_q[VALUE_W-1], last_q} + {value_q[VALUE_W-1], value_q};
  assign read_ok   = (ec_q >= EC_W'(2)) &&
                     (IDXC_W'(idx_q) < IDXC_W'(ec_q - EC_W'(1))) &&
                     (IDXC_W'(idx_q) < IDXC_W'(MAX_BINS));
  assign cnt_cur   = vld_q[lo_q[BIN_AW-1:0]] ? cnt_rdata : '0;
  assign out_load  = !out_vld_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    ec_d         = ec_q;
    samples_d    = samples_q;
    vld_d        = vld_q;
    first_d      = first_q;
    last_d       = last_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_status_d = res_status_q;
    res_bin_d    = res_bin_q;
    res_count_d  = res_count_q;
    out_vld_d    = out_vld_q;
    edge_we      = 1'b0;
    edge_waddr   = '0;
    edge_wdata   = value_q;
    edge_re      = 1'b0;
    edge_raddr   = mid_q[EDGE_AW-1:0];
    cnt_we       = 1'b0;
    cnt_re       = 1'b0;
    cnt_wdata    = cnt_cur + COUNT_W'(1);

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_status_d = STAT_OK;
        res_bin_d    = '0;
        res_count_d  = '0;
        state_d      = ST_EMIT;
        case (mode_q)
          MODE_SAMPLE: begin
            samples_d = samples_q + COUNT_W'(1);
            if (ec_q < EC_W'(2) || value_q < first_q || value_q >= last_q) begin
              res_status_d = STAT_OUTSIDE;
            end else begin
              lo_d    = '0;
              hi_d    = ec_q - EC_W'(1);
              state_d = ST_SRCH;
            end
          end
          MODE_SET: begin
            if (ec_q != '0) begin
              res_status_d = STAT_BAD;
            end else begin
              edge_we    = 1'b1;
              edge_waddr = '0;
              first_d    = value_q;
              last_d     = value_q;
              ec_d       = EC_W'(1);
            end
          end
          MODE_APPEND: begin
            if (ec_q == '0 || ec_q >= EC_W'(MAX_BINS + 1) || value_q[VALUE_W-1] ||
                $signed(next_edge) > $signed({1'b0, {(VALUE_W-1){1'b1}}})) begin
              res_status_d = STAT_BAD;
            end else begin
              edge_we    = 1'b1;
              edge_waddr = ec_q[EDGE_AW-1:0];
              edge_wdata = next_edge[VALUE_W-1:0];
              last_d     = next_edge[VALUE_W-1:0];
              ec_d       = ec_q + EC_W'(1);
              lo_d       = ec_q - EC_W'(1);
              state_d    = ST_CRD;
            end
          end
          MODE_READ: begin
            if (read_ok) begin
              lo_d    = EC_W'(idx_q);
              state_d = ST_CRD;
            end else begin
              res_status_d = STAT_BAD;
              res_bin_d    = idx_q;
            end
          end
          MODE_CLEAR: begin
            vld_d     = '0;
            samples_d = '0;
          end
          default: begin
            res_status_d = STAT_BAD;
          end
        endcase
      end
      ST_SRCH: begin
        if (hi_q > lo_q + EC_W'(1)) begin
          mid_d      = mid_sum[EC_W:1];
          edge_re    = 1'b1;
          edge_raddr = mid_sum[EDGE_AW:1];
          state_d    = ST_CMP;
        end else begin
          state_d = ST_CRD;
        end
      end
      ST_CMP: begin
        if (value_q >= $signed(edge_rdata)) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SRCH;
      end
      ST_CRD: begin
        cnt_re  = 1'b1;
        state_d = ST_CWR;
      end
      ST_CWR: begin
        res_status_d = STAT_OK;
        res_bin_d    = INDEX_W'(lo_q);
        if (mode_q == MODE_SAMPLE) begin
          cnt_we                     = 1'b1;
          vld_d[lo_q[BIN_AW-1:0]]    = 1'b1;
          res_count_d                = cnt_wdata;
        end else begin
          res_count_d = cnt_cur;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ec_q      <= '0;
      samples_q <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ec_q      <= ec_d;
      samples_q <= samples_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= in_i.mode;
      value_q <= in_i.value;
      idx_q   <= in_i.index;
    end
    first_q      <= first_d;
    last_q       <= last_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_status_q <= res_status_d;
    res_bin_q    <= res_bin_d;
    res_count_q  <= res_count_d;
    if (state_q == ST_EMIT && out_load) begin
      out_status_q <= res_status_q;
      out_bin_q    <= res_bin_q;
      out_count_q  <= res_count_q;
      out_total_q  <= samples_q;
    end
  end

  vbh_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  vbh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_BINS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (lo_q[BIN_AW-1:0]),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (lo_q[BIN_AW-1:0]),
    .rdata_o (cnt_rdata)
  );

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_status_q;
  assign out_o.bin_num      = out_bin_q;
  assign out_o.count        = out_count_q;
  assign out_o.sample_total = out_total_q;

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_EXEC)
    else $error("accepted beat did not start execution");

  a_search_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH || state_q == ST_CMP) |-> hi_q > lo_q)
    else $error("search bounds crossed");

  a_edge_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= EC_W'(MAX_BINS + 1))
    else $error("edge count beyond table");

  a_count_rmw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> $past(cnt_re))
    else $error("count write without preceding read");

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_load) |=> state_q == ST_EMIT && out_vld_q)
    else $error("result left while output busy");

endmodule
